/* src/bfme_pkg.sv */
// ----------------------------------------------------------------------------
// bfme_pkg
// Shared types and constants of the bit field move engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfme_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned DEPTH_WORDS = 1024;
  localparam int unsigned IDX_W       = $clog2(DEPTH_WORDS);
  localparam int unsigned OFF_W       = $clog2(WORD_BITS);
  localparam int unsigned ADDR_W      = IDX_W + OFF_W;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_COPY  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  word_index;
    logic [31:0] word_value;
    logic [14:0] source_bit;
    logic [14:0] dest_bit;
    logic [15:0] bit_count;
  } bfme_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } bfme_out_t;

  // control of one destination word merge
  typedef struct packed {
    logic [OFF_W-1:0] shift;
    logic [OFF_W:0]   lo_off;
    logic [OFF_W:0]   hi_off;
  } merge_ctl_t;

endpackage

`default_nettype wire

/* src/bfme_ram.sv */
// ----------------------------------------------------------------------------
// bfme_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/bfme_merge.sv */
// ----------------------------------------------------------------------------
// bfme_merge
// Funnel shift of two source words and masked merge into a destination word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfme_merge (
  input  wire bfme_pkg::merge_ctl_t           ctl_i,
  input  wire logic [bfme_pkg::WORD_BITS-1:0] src_hi_i,
  input  wire logic [bfme_pkg::WORD_BITS-1:0] src_lo_i,
  input  wire logic [bfme_pkg::WORD_BITS-1:0] old_i,
  output logic      [bfme_pkg::WORD_BITS-1:0] new_o
);
  import bfme_pkg::*;

  logic [2*WORD_BITS-1:0] window;
  logic [WORD_BITS-1:0]   mask;

  // shift source pair and keep only the field positions
  always_comb begin
    window = {src_hi_i, src_lo_i} << ctl_i.shift;
    for (int o = 0; o < WORD_BITS; o++) begin
      mask[WORD_BITS-1-o] = ((OFF_W+1)'(o) >= ctl_i.lo_off) &&
                            ((OFF_W+1)'(o) <  ctl_i.hi_off);
    end
    new_o = (window[2*WORD_BITS-1:WORD_BITS] & mask) | (old_i & ~mask);
  end

endmodule

`default_nettype wire

/* src/bit_field_move_engine.sv */
// ----------------------------------------------------------------------------
// bit_field_move_engine
// Word memory with word write, word read and bit field copy (memmove order).
// ----------------------------------------------------------------------------
//  channel | signals                            | beat
//  input   | in_valid_i, in_ready_o, in_data_i  | one operation
//  output  | out_valid_o, out_ready_i, out_data_o | one result
//
// A copy walks each destination word touched in turn, sequenced by the
// single RAM port pair (two source reads, one destination read, one write
// per word).
// One operation is held at a time; in_ready_o is high only when idle.
// The result register holds a beat until taken; a finished item waits for it.
// Reset clears control and holding registers; memory contents are undefined
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_field_move_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bfme_pkg::bfme_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bfme_pkg::bfme_out_t      out_data_o
);
  import bfme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RDW, S_RA, S_RB, S_RC, S_WR, S_DONE
  } state_e;

  localparam logic [ADDR_W+1:0] TotalBits = (ADDR_W+2)'(WORD_BITS * DEPTH_WORDS);

  state_e               state_q;
  bfme_in_t             item_q;
  logic [IDX_W-1:0]     dw_q;
  logic                 fwd_q;
  logic [WORD_BITS-1:0] a_q, b_q;
  logic [31:0]          rd_q;
  logic                 st_q;
  bfme_out_t            out_q;
  logic                 out_valid_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, merged;
  merge_ctl_t           mctl;

  logic [ADDR_W+1:0]    delta, sa, dst_end, dst_last, src_end;
  logic [IDX_W-1:0]     w0, w1, first_w, last_w, stop_w;
  logic                 idx_ok, copy_err;

  // address arithmetic of the copy
  always_comb begin
    delta    = {2'b0, item_q.source_bit} - {2'b0, item_q.dest_bit};
    sa       = {2'b0, dw_q, OFF_W'(0)} + delta;
    w0       = sa[ADDR_W-1:OFF_W];
    w1       = w0 + IDX_W'(1);
    dst_end  = {2'b0, item_q.dest_bit} + {1'b0, item_q.bit_count};
    src_end  = {2'b0, item_q.source_bit} + {1'b0, item_q.bit_count};
    dst_last = dst_end - (ADDR_W+2)'(1);
    first_w  = item_q.dest_bit[ADDR_W-1:OFF_W];
    last_w   = dst_last[ADDR_W-1:OFF_W];
    stop_w   = fwd_q ? last_w : first_w;
    copy_err = (src_end > TotalBits) || (dst_end > TotalBits);
    idx_ok   = {1'b0, item_q.word_index} < (IDX_W+1)'(DEPTH_WORDS);
    mctl.shift  = sa[OFF_W-1:0];
    mctl.lo_off = (dw_q == first_w) ? {1'b0, item_q.dest_bit[OFF_W-1:0]} : '0;
    mctl.hi_off = (dw_q == last_w) ? ({1'b0, dst_last[OFF_W-1:0]} + (OFF_W+1)'(1))
                                   : (OFF_W+1)'(WORD_BITS);
  end

  // memory port drive per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_q.word_index;
    ram_wdata = item_q.word_value;
    ram_raddr = item_q.word_index;
    case (state_q)
      S_EXEC: ram_we = (item_q.op == OP_WRITE) && idx_ok;
      S_RA:   ram_raddr = w0;
      S_RB:   ram_raddr = w1;
      S_RC:   ram_raddr = dw_q;
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dw_q;
        ram_wdata = merged;
      end
      default: ;
    endcase
  end

  bfme_ram #(.Width(WORD_BITS), .Depth(DEPTH_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfme_merge u_merge (
    .ctl_i    (mctl),
    .src_hi_i (a_q),
    .src_lo_i (b_q),
    .old_i    (ram_rdata),
    .new_o    (merged)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      item_q      <= '0;
      dw_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      rd_q        <= '0;
      st_q        <= 1'b0;
      out_q       <= '0;
    end else begin
      // drop a taken beat unless a new one replaces it below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            rd_q    <= '0;
            st_q    <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (item_q.op)
            OP_WRITE: begin
              st_q    <= !idx_ok;
              state_q <= S_DONE;
            end
            OP_READ: begin
              st_q    <= !idx_ok;
              state_q <= S_RDW;
            end
            OP_COPY: begin
              fwd_q <= item_q.dest_bit < item_q.source_bit;
              dw_q  <= (item_q.dest_bit < item_q.source_bit) ? first_w : last_w;
              if (copy_err) begin
                st_q    <= 1'b1;
                state_q <= S_DONE;
              end else if ((item_q.bit_count == '0) ||
                           (item_q.source_bit == item_q.dest_bit)) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_RA;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_RDW: begin
          if (idx_ok) begin
            rd_q <= 32'(ram_rdata);
          end
          state_q <= S_DONE;
        end
        S_RA: state_q <= S_RB;
        S_RB: begin
          a_q     <= ram_rdata;
          state_q <= S_RC;
        end
        S_RC: begin
          b_q     <= ram_rdata;
          state_q <= S_WR;
        end
        S_WR: begin
          if (dw_q == stop_w) begin
            state_q <= S_DONE;
          end else begin
            dw_q    <= fwd_q ? dw_q + IDX_W'(1) : dw_q - IDX_W'(1);
            state_q <= S_RA;
          end
        end
        S_DONE: begin
          // hand over once the result register is free
          if (!out_valid_q || out_ready_i) begin
            out_q.read_value <= rd_q;
            out_q.status     <= st_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* src/bfme_checker.sv */
// ----------------------------------------------------------------------------
// bfme_checker
// Port level checks of the bit field move engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfme_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire bfme_pkg::bfme_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire bfme_pkg::bfme_out_t out_data_o
);

  // drop ready for the beat just taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting a beat");

  // an error result never carries read data
  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.read_value == '0)
    else $error("error result with nonzero read data");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // raise a new result only as the engine goes back to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while busy");

endmodule

bind bit_field_move_engine bfme_checker u_bfme_checker (.*);

`default_nettype wire
